// ===== src/i2cms_pkg.sv =====
package i2cms_pkg;

	localparam logic [2:0] FUNC_BUS_CHECK = 3'd0;
	localparam logic [2:0] FUNC_START     = 3'd1;
	localparam logic [2:0] FUNC_RSTART    = 3'd2;
	localparam logic [2:0] FUNC_WRITE     = 3'd3;
	localparam logic [2:0] FUNC_READ      = 3'd4;
	localparam logic [2:0] FUNC_STOP      = 3'd5;
	localparam logic [2:0] FUNC_SAMPLE    = 3'd6;

	localparam logic [2:0] BIT_LAST = 3'd7;
	localparam logic [4:0] WRITE_BIT_STEPS = 5'd24;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'b0001,
		PH_WAIT_BUS = 4'b0010,
		PH_WAIT_ACK = 4'b0100,
		PH_WAIT_BIT = 4'b1000
	} phase_t;

	typedef enum logic [3:0] {
		JOB_BUS_CHECK,
		JOB_BUS_ANS,
		JOB_START,
		JOB_RSTART,
		JOB_WRITE,
		JOB_ACK,
		JOB_READ,
		JOB_BIT_MORE,
		JOB_BIT_LAST,
		JOB_STOP
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] data;
		logic       flag;
	} job_t;

	typedef enum logic [1:0] {
		LINE_NONE,
		LINE_SDA,
		LINE_SCL
	} line_t;

	typedef struct packed {
		line_t line;
		logic  value;
		logic  last;
		logic  need;
		logic  done;
	} step_t;

	typedef struct packed {
		logic       sda_release;
		logic       scl_release;
		logic       need_sample;
		logic       run_end;
		logic       cmd_done;
		logic [7:0] answer;
	} result_t;

endpackage

// ===== src/i2cms_fifo.sv =====
module i2cms_fifo #(
	parameter int W     = 16,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full) else $error("write into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count out of range");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CW'(1) && do_rd && !do_wr) |=> empty)
		else $error("queue not empty after last read");

endmodule

// ===== src/i2cms_front.sv =====
module i2cms_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                job_full,
	input  logic [2:0]          func,
	input  logic [7:0]          data_byte,
	input  logic                nack_last,
	input  logic                sda_in,
	input  logic                scl_in,
	output logic                job_wr,
	output i2cms_pkg::job_t     job
);
	import i2cms_pkg::*;

	phase_t     phase_q;
	logic [7:0] shift_q;
	logic [2:0] count_q;
	logic       nack_q;

	phase_t     phase_d;
	logic [7:0] shift_d;
	logic [2:0] count_d;
	logic       nack_d;
	logic       has_job;
	logic       accept;
	logic [7:0] shift_in;

	assign accept   = push && !job_full;
	assign job_wr   = accept && has_job;
	assign shift_in = {shift_q[6:0], sda_in};

	always_comb begin
		phase_d  = phase_q;
		shift_d  = shift_q;
		count_d  = count_q;
		nack_d   = nack_q;
		has_job  = 1'b1;
		job.kind = JOB_STOP;
		job.data = data_byte;
		job.flag = 1'b0;
		case (func)
			FUNC_BUS_CHECK: begin
				job.kind = JOB_BUS_CHECK;
				phase_d  = PH_WAIT_BUS;
			end
			FUNC_START: begin
				job.kind = JOB_START;
				phase_d  = PH_WAIT_ACK;
			end
			FUNC_RSTART: begin
				job.kind = JOB_RSTART;
				phase_d  = PH_WAIT_ACK;
			end
			FUNC_WRITE: begin
				job.kind = JOB_WRITE;
				phase_d  = PH_WAIT_ACK;
			end
			FUNC_READ: begin
				job.kind = JOB_READ;
				shift_d  = '0;
				count_d  = '0;
				nack_d   = nack_last;
				phase_d  = PH_WAIT_BIT;
			end
			FUNC_STOP: begin
				job.kind = JOB_STOP;
				job.data = '0;
				phase_d  = PH_IDLE;
			end
			FUNC_SAMPLE: begin
				case (phase_q)
					PH_WAIT_BUS: begin
						job.kind = JOB_BUS_ANS;
						job.data = {7'b0, sda_in & scl_in};
						phase_d  = PH_IDLE;
					end
					PH_WAIT_ACK: begin
						job.kind = JOB_ACK;
						job.data = {7'b0, !sda_in};
						phase_d  = PH_IDLE;
					end
					PH_WAIT_BIT: begin
						shift_d  = shift_in;
						count_d  = count_q + 1'b1;
						job.data = shift_in;
						job.flag = nack_q;
						if (count_q == BIT_LAST) begin
							job.kind = JOB_BIT_LAST;
							phase_d  = PH_IDLE;
						end else begin
							job.kind = JOB_BIT_MORE;
						end
					end
					default: begin
						has_job = 1'b0;
					end
				endcase
			end
			default: begin
				has_job = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			shift_q <= '0;
			count_q <= '0;
			nack_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			shift_q <= shift_d;
			count_q <= count_d;
			nack_q  <= nack_d;
		end
	end

endmodule

// ===== src/i2cms_back.sv =====
module i2cms_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_empty,
	input  i2cms_pkg::job_t     job,
	output logic                job_rd,
	input  logic                out_full,
	output logic                out_wr,
	output i2cms_pkg::result_t  out_data
);
	import i2cms_pkg::*;

	function automatic step_t step_decode(job_kind_t kind, logic [4:0] step,
			logic [7:0] data, logic flag);
		step_t      s;
		logic [4:0] pre;
		logic [4:0] k;
		logic [8:0] prod;
		logic [3:0] q;
		logic [4:0] r;
		logic [7:0] sh;
		s = '{line: LINE_NONE, value: 1'b0, last: 1'b0, need: 1'b0, done: 1'b0};
		pre = (kind == JOB_RSTART) ? 5'd4 : ((kind == JOB_START) ? 5'd2 : 5'd0);
		k = step - pre;
		prod = {4'b0, k} * 9'd11;
		q = prod[8:5];
		r = k - {q, 1'b0} - {1'b0, q};
		sh = data << q[2:0];
		case (kind)
			JOB_BUS_CHECK: begin
				case (step[1:0])
					2'd0: s = '{LINE_SDA, 1'b0, 1'b0, 1'b0, 1'b0};
					2'd1: s = '{LINE_SCL, 1'b0, 1'b0, 1'b0, 1'b0};
					2'd2: s = '{LINE_SDA, 1'b1, 1'b0, 1'b0, 1'b0};
					default: s = '{LINE_SCL, 1'b1, 1'b1, 1'b1, 1'b0};
				endcase
			end
			JOB_BUS_ANS: begin
				s = '{LINE_NONE, 1'b0, 1'b1, 1'b0, 1'b1};
			end
			JOB_START, JOB_RSTART, JOB_WRITE: begin
				if (step < pre) begin
					if (kind == JOB_RSTART) begin
						case (step[1:0])
							2'd0: s = '{LINE_SDA, 1'b1, 1'b0, 1'b0, 1'b0};
							2'd1: s = '{LINE_SCL, 1'b1, 1'b0, 1'b0, 1'b0};
							2'd2: s = '{LINE_SDA, 1'b0, 1'b0, 1'b0, 1'b0};
							default: s = '{LINE_SCL, 1'b0, 1'b0, 1'b0, 1'b0};
						endcase
					end else if (step[0] == 1'b0) begin
						s = '{LINE_SDA, 1'b0, 1'b0, 1'b0, 1'b0};
					end else begin
						s = '{LINE_SCL, 1'b0, 1'b0, 1'b0, 1'b0};
					end
				end else if (k < WRITE_BIT_STEPS) begin
					case (r)
						5'd0: s = '{LINE_SDA, sh[7], 1'b0, 1'b0, 1'b0};
						5'd1: s = '{LINE_SCL, 1'b1, 1'b0, 1'b0, 1'b0};
						default: s = '{LINE_SCL, 1'b0, 1'b0, 1'b0, 1'b0};
					endcase
				end else if (k == WRITE_BIT_STEPS) begin
					s = '{LINE_SDA, 1'b1, 1'b0, 1'b0, 1'b0};
				end else begin
					s = '{LINE_SCL, 1'b1, 1'b1, 1'b1, 1'b0};
				end
			end
			JOB_ACK: begin
				if (step[0] == 1'b0) begin
					s = '{LINE_SCL, 1'b0, 1'b0, 1'b0, 1'b0};
				end else begin
					s = '{LINE_SDA, 1'b0, 1'b1, 1'b0, 1'b1};
				end
			end
			JOB_READ: begin
				if (step[0] == 1'b0) begin
					s = '{LINE_SDA, 1'b1, 1'b0, 1'b0, 1'b0};
				end else begin
					s = '{LINE_SCL, 1'b1, 1'b1, 1'b1, 1'b0};
				end
			end
			JOB_BIT_MORE: begin
				if (step[0] == 1'b0) begin
					s = '{LINE_SCL, 1'b0, 1'b0, 1'b0, 1'b0};
				end else begin
					s = '{LINE_SCL, 1'b1, 1'b1, 1'b1, 1'b0};
				end
			end
			JOB_BIT_LAST: begin
				case (step[2:0])
					3'd0: s = '{LINE_SCL, 1'b0, 1'b0, 1'b0, 1'b0};
					3'd1: s = '{LINE_SDA, flag, 1'b0, 1'b0, 1'b0};
					3'd2: s = '{LINE_SCL, 1'b1, 1'b0, 1'b0, 1'b0};
					3'd3: s = '{LINE_SCL, 1'b0, 1'b0, 1'b0, 1'b0};
					default: s = '{LINE_SDA, 1'b0, 1'b1, 1'b0, 1'b1};
				endcase
			end
			default: begin
				case (step[1:0])
					2'd0: s = '{LINE_SDA, 1'b0, 1'b0, 1'b0, 1'b0};
					2'd1: s = '{LINE_SCL, 1'b1, 1'b0, 1'b0, 1'b0};
					default: s = '{LINE_SDA, 1'b1, 1'b1, 1'b0, 1'b1};
				endcase
			end
		endcase
		return s;
	endfunction

	logic       busy_q;
	job_t       job_q;
	logic [4:0] step_q;
	logic       sda_q;
	logic       scl_q;

	step_t      cur;
	logic       emit;
	logic       fin;
	logic       sda_nxt;
	logic       scl_nxt;

	assign cur     = step_decode(job_q.kind, step_q, job_q.data, job_q.flag);
	assign emit    = busy_q && !out_full;
	assign fin     = emit && cur.last;
	assign job_rd  = !job_empty && (!busy_q || fin);
	assign out_wr  = emit;
	assign sda_nxt = (cur.line == LINE_SDA) ? cur.value : sda_q;
	assign scl_nxt = (cur.line == LINE_SCL) ? cur.value : scl_q;

	always_comb begin
		out_data.sda_release = sda_nxt;
		out_data.scl_release = scl_nxt;
		out_data.need_sample = cur.need;
		out_data.run_end     = cur.last;
		out_data.cmd_done    = cur.done;
		out_data.answer      = cur.done ? job_q.data : 8'd0;
	end

	always_ff @(posedge clk) begin
		if (job_rd) begin
			job_q <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			sda_q  <= 1'b1;
			scl_q  <= 1'b1;
		end else begin
			if (emit) begin
				sda_q  <= sda_nxt;
				scl_q  <= scl_nxt;
			end
			if (job_rd) begin
				step_q <= '0;
			end else if (emit) begin
				step_q <= step_q + 1'b1;
			end
			if (job_rd) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/i2c_master_bit_sequencer_unit.sv =====
// i2c master bit sequencer: byte-level commands in, open-drain line events out
// input queue: push/full with func, data_byte, nack_last, sda_in, scl_in;
//   a request is taken at an edge with push high and full low
// result queue: empty/pop; the oldest line event sits on the result ports while
//   empty is low and leaves at an edge with pop high
// each command request yields a run of 2 to 30 events, one per cycle while the
//   result queue has room; a pin sample request yields 1 to 5; a sample with
//   nothing pending and func 7 yield none
// a taken request goes through the job queue, the job register and the result
//   queue before its first event is visible on the result ports
// throughput: a new request is taken every cycle while the job queue has room;
//   the event generator runs one event per cycle while the result queue has room
// reset clears both queues and the sequencing state, lines released high
// a stalled result side fills the result queue, then the job queue, then
//   raises full; nothing is dropped
module i2c_master_bit_sequencer_unit #(
	parameter int JOB_DEPTH = 4,
	parameter int OUT_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] func,
	input  logic [7:0] data_byte,
	input  logic       nack_last,
	input  logic       sda_in,
	input  logic       scl_in,
	output logic       empty,
	input  logic       pop,
	output logic       sda_release,
	output logic       scl_release,
	output logic       need_sample,
	output logic       run_end,
	output logic       cmd_done,
	output logic [7:0] answer
);
	import i2cms_pkg::*;

	logic    job_wr;
	logic    job_full;
	logic    job_empty;
	logic    job_rd;
	job_t    job_in;
	job_t    job_out;
	logic    out_wr;
	logic    out_full;
	result_t out_in;
	result_t out_out;

	assign full = job_full;

	i2cms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.job_full  (job_full),
		.func      (func),
		.data_byte (data_byte),
		.nack_last (nack_last),
		.sda_in    (sda_in),
		.scl_in    (scl_in),
		.job_wr    (job_wr),
		.job       (job_in)
	);

	i2cms_fifo #(
		.W     ($bits(job_t)),
		.DEPTH (JOB_DEPTH)
	) u_job_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_wr),
		.wr_data (job_in),
		.full    (job_full),
		.rd_en   (job_rd),
		.rd_data (job_out),
		.empty   (job_empty)
	);

	i2cms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job       (job_out),
		.job_rd    (job_rd),
		.out_full  (out_full),
		.out_wr    (out_wr),
		.out_data  (out_in)
	);

	i2cms_fifo #(
		.W     ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data (out_in),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (out_out),
		.empty   (empty)
	);

	assign sda_release = out_out.sda_release;
	assign scl_release = out_out.scl_release;
	assign need_sample = out_out.need_sample;
	assign run_end     = out_out.run_end;
	assign cmd_done    = out_out.cmd_done;
	assign answer      = out_out.answer;

endmodule

// ===== sim/tb_i2c_master_bit_sequencer_unit.sv =====
module tb_i2c_master_bit_sequencer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cms_pkg::*;

	localparam logic [2:0] FUNC_NONE = 3'd7;
	localparam int RANDOM_ITEMS = 225;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		logic [2:0] fn;
		logic [7:0] dbyte;
		logic       nack;
		logic       sda;
		logic       scl;
		logic       drain;
	} bus_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [2:0] func = '0;
	logic [7:0] data_byte = '0;
	logic       nack_last = 1'b0;
	logic       sda_in = 1'b0;
	logic       scl_in = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic       sda_release;
	logic       scl_release;
	logic       need_sample;
	logic       run_end;
	logic       cmd_done;
	logic [7:0] answer;

	i2c_master_bit_sequencer_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.func        (func),
		.data_byte   (data_byte),
		.nack_last   (nack_last),
		.sda_in      (sda_in),
		.scl_in      (scl_in),
		.empty       (empty),
		.pop         (pop),
		.sda_release (sda_release),
		.scl_release (scl_release),
		.need_sample (need_sample),
		.run_end     (run_end),
		.cmd_done    (cmd_done),
		.answer      (answer)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	bus_req_t pending_reqs[$];
	result_t  line_events[$];
	bus_req_t offered;
	int       errors = 0;
	int       random_count = 0;
	bit       drain_next = 1'b0;

	// predictor state
	phase_t     bus_phase = PH_IDLE;
	logic [7:0] rx_shift = '0;
	logic [3:0] rx_count = '0;
	logic       rx_nack = 1'b0;
	logic       lvl_sda = 1'b1;
	logic       lvl_scl = 1'b1;

	task automatic put_line_event();
		result_t ev;
		ev = '0;
		ev.sda_release = lvl_sda;
		ev.scl_release = lvl_scl;
		line_events.push_back(ev);
	endtask

	task automatic drive_sda(logic v);
		lvl_sda = v;
		put_line_event();
	endtask

	task automatic drive_scl(logic v);
		lvl_scl = v;
		put_line_event();
	endtask

	task automatic end_run(logic need, logic done, logic [7:0] ans);
		result_t ev;
		ev = line_events.pop_back();
		ev.need_sample = need;
		ev.run_end = 1'b1;
		ev.cmd_done = done;
		ev.answer = ans;
		line_events.push_back(ev);
	endtask

	task automatic shift_out_byte(logic [7:0] v);
		for (int b = 7; b >= 0; b--) begin
			drive_sda(v[b]);
			drive_scl(1'b1);
			drive_scl(1'b0);
		end
		drive_sda(1'b1);
		drive_scl(1'b1);
		bus_phase = PH_WAIT_ACK;
		end_run(1'b1, 1'b0, 8'd0);
	endtask

	task automatic predict_events(bus_req_t r);
		if (r.fn == FUNC_SAMPLE) begin
			case (bus_phase)
				PH_WAIT_BUS: begin
					bus_phase = PH_IDLE;
					put_line_event();
					end_run(1'b0, 1'b1, {7'd0, r.sda & r.scl});
				end
				PH_WAIT_ACK: begin
					bus_phase = PH_IDLE;
					drive_scl(1'b0);
					drive_sda(1'b0);
					end_run(1'b0, 1'b1, {7'd0, ~r.sda});
				end
				PH_WAIT_BIT: begin
					rx_shift = {rx_shift[6:0], r.sda};
					rx_count = rx_count + 4'd1;
					drive_scl(1'b0);
					if (rx_count < 4'd8) begin
						drive_scl(1'b1);
						end_run(1'b1, 1'b0, 8'd0);
					end else begin
						bus_phase = PH_IDLE;
						drive_sda(rx_nack);
						drive_scl(1'b1);
						drive_scl(1'b0);
						drive_sda(1'b0);
						end_run(1'b0, 1'b1, rx_shift);
					end
				end
				default: ;
			endcase
		end else if (r.fn != FUNC_NONE) begin
			bus_phase = PH_IDLE;
			case (r.fn)
				FUNC_BUS_CHECK: begin
					drive_sda(1'b0);
					drive_scl(1'b0);
					drive_sda(1'b1);
					drive_scl(1'b1);
					bus_phase = PH_WAIT_BUS;
					end_run(1'b1, 1'b0, 8'd0);
				end
				FUNC_RSTART: begin
					drive_sda(1'b1);
					drive_scl(1'b1);
					drive_sda(1'b0);
					drive_scl(1'b0);
					shift_out_byte(r.dbyte);
				end
				FUNC_START: begin
					drive_sda(1'b0);
					drive_scl(1'b0);
					shift_out_byte(r.dbyte);
				end
				FUNC_WRITE: shift_out_byte(r.dbyte);
				FUNC_READ: begin
					rx_shift = '0;
					rx_count = '0;
					rx_nack = r.nack;
					drive_sda(1'b1);
					drive_scl(1'b1);
					bus_phase = PH_WAIT_BIT;
					end_run(1'b1, 1'b0, 8'd0);
				end
				default: begin
					drive_sda(1'b0);
					drive_scl(1'b1);
					drive_sda(1'b1);
					end_run(1'b0, 1'b1, 8'd0);
				end
			endcase
		end
	endtask

	// stimulus building
	task automatic add_req(logic [2:0] fn, logic [7:0] d, logic n, logic s, logic c);
		bus_req_t r;
		r.fn = fn;
		r.dbyte = d;
		r.nack = n;
		r.sda = s;
		r.scl = c;
		r.drain = drain_next;
		drain_next = 1'b0;
		pending_reqs.push_back(r);
	endtask

	task automatic add_cmd(logic [2:0] fn, logic [7:0] d, logic n);
		add_req(fn, d, n, 1'($urandom), 1'($urandom));
		random_count++;
	endtask

	task automatic add_sample(logic s, logic c);
		add_req(FUNC_SAMPLE, 8'($urandom), 1'($urandom), s, c);
		random_count++;
	endtask

	task automatic add_ack_sample();
		// sometimes leave the ack wait pending so the next command drops it
		if ($urandom_range(0, 11) != 0)
			add_sample(1'($urandom_range(0, 3) == 0), 1'($urandom));
	endtask

	task automatic add_read_byte();
		int bits;
		bits = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 7) : 8;
		add_cmd(FUNC_READ, 8'($urandom), 1'($urandom));
		repeat (bits) add_sample(1'($urandom), 1'($urandom));
	endtask

	task automatic add_transaction();
		int ops;
		if ($urandom_range(0, 1)) begin
			add_cmd(FUNC_BUS_CHECK, 8'($urandom), 1'($urandom));
			add_sample(1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 3) != 0));
		end
		add_cmd(FUNC_START, 8'($urandom), 1'($urandom));
		add_ack_sample();
		ops = $urandom_range(1, 3);
		repeat (ops) begin
			case ($urandom_range(0, 4))
				0, 1: begin
					add_cmd(FUNC_WRITE, 8'($urandom), 1'($urandom));
					add_ack_sample();
				end
				2, 3: add_read_byte();
				default: begin
					add_cmd(FUNC_RSTART, 8'($urandom), 1'($urandom));
					add_ack_sample();
				end
			endcase
		end
		add_cmd(FUNC_STOP, 8'($urandom), 1'($urandom));
	endtask

	task automatic build_directed();
		logic [7:0] pattern;
		pattern = 8'hA5;
		add_req(FUNC_SAMPLE, 8'hFF, 1'b1, 1'b1, 1'b1);
		add_req(FUNC_NONE, 8'hFF, 1'b1, 1'b1, 1'b1);
		add_req(FUNC_BUS_CHECK, 8'h00, 1'b0, 1'b0, 1'b0);
		add_req(FUNC_SAMPLE, 8'h00, 1'b0, 1'b1, 1'b1);
		add_req(FUNC_BUS_CHECK, 8'h00, 1'b0, 1'b0, 1'b0);
		add_req(FUNC_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b1);
		add_req(FUNC_START, 8'hFF, 1'b0, 1'b0, 1'b0);
		add_req(FUNC_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b0);
		add_req(FUNC_WRITE, 8'h00, 1'b0, 1'b0, 1'b0);
		add_req(FUNC_SAMPLE, 8'h00, 1'b0, 1'b1, 1'b0);
		add_req(FUNC_READ, 8'h00, 1'b1, 1'b0, 1'b0);
		for (int b = 7; b >= 0; b--)
			add_req(FUNC_SAMPLE, 8'h00, 1'b0, pattern[b], 1'b0);
		// the stop after this restart drops its pending ack wait
		add_req(FUNC_RSTART, 8'h80, 1'b0, 1'b0, 1'b0);
		add_req(FUNC_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
		add_req(FUNC_READ, 8'h00, 1'b0, 1'b0, 1'b0);
		add_req(FUNC_SAMPLE, 8'h00, 1'b0, 1'b1, 1'b0);
		add_req(FUNC_START, 8'h01, 1'b0, 1'b0, 1'b0);
		add_req(FUNC_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b0);
	endtask

	task automatic build_random();
		drain_next = 1'b1;
		while (random_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 3))
					add_req(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
						1'($urandom));
			end else begin
				if ($urandom_range(0, 9) == 0)
					drain_next = 1'b1;
				add_transaction();
			end
		end
	endtask

	// request driver
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		bit go;
		if (!arst_n) begin
			push <= 1'b0;
			burst_left <= 1;
			gap_left <= 0;
		end else begin
			go = push;
			if (push && !full) begin
				predict_events(offered);
				go = 1'b0;
			end
			if (!go) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() != 0 &&
						!(pending_reqs[0].drain && line_events.size() != 0)) begin
					offered = pending_reqs.pop_front();
					go = 1'b1;
					func <= offered.fn;
					data_byte <= offered.dbyte;
					nack_last <= offered.nack;
					sda_in <= offered.sda;
					scl_in <= offered.scl;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 3) == 0) ?
							$urandom_range(20, 60) : $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end
				end
			end
			push <= go;
		end
	end

	// result monitor
	int   results_seen;
	int   hold_left;
	bit   hold_done;
	int   mask_age;
	logic [7:0] pop_mask;
	logic [2:0] mask_pos;

	task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		bit      next_pop;
		if (!arst_n) begin
			pop <= 1'b0;
			results_seen <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
			mask_age <= 0;
			pop_mask <= 8'hFF;
			mask_pos <= '0;
		end else begin
			if (pop && !empty) begin
				results_seen++;
				if (line_events.size() == 0) begin
					$display("%0t: unexpected result expected none, got sda=%b scl=%b ans=%0h",
						$time, sda_release, scl_release, answer);
					errors++;
				end else begin
					want = line_events.pop_front();
					compare_field("sda_release", want.sda_release, sda_release);
					compare_field("scl_release", want.scl_release, scl_release);
					compare_field("need_sample", want.need_sample, need_sample);
					compare_field("run_end", want.run_end, run_end);
					compare_field("cmd_done", want.cmd_done, cmd_done);
					compare_field("answer", want.answer, answer);
				end
			end
			// one long hold so the block backs up into full
			if (!hold_done && results_seen >= 60) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			mask_age++;
			if (mask_age >= 50) begin
				mask_age = 0;
				pop_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
			end
			mask_pos++;
			if (hold_left > 0) begin
				hold_left--;
				next_pop = 1'b0;
			end else begin
				next_pop = pop_mask[mask_pos];
			end
			pop <= next_pop;
		end
	end

	// stall watchdog
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		build_directed();
		build_random();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (pending_reqs.size() != 0 || push);
		while (line_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && line_events.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== i2c_master_bit_sequencer_unit.f =====
src/i2cms_pkg.sv
src/i2cms_fifo.sv
src/i2cms_front.sv
src/i2cms_back.sv
src/i2c_master_bit_sequencer_unit.sv
sim/tb_i2c_master_bit_sequencer_unit.sv
